/* sv/cdt_pkg.sv */
// shared types, constants and keyword tables for the c declaration tokenizer
// used by the core, the record queue and the port checker
package cdt_pkg;

  localparam int MAX_TOKENS_DEF    = 50;
  localparam int MAX_TOKEN_LEN_DEF = 64;
  localparam int POSITION_BITS_DEF = 10;

  // field widths of a result record
  localparam int IDX_W     = 6;
  localparam int LEN_W     = 7;
  localparam int POS_OUT_W = 10;

  localparam int REC_FIFO_DEPTH = 4;
  localparam int REC_PTR_W      = $clog2(REC_FIFO_DEPTH);
  localparam int REC_CNT_W      = REC_PTR_W + 1;

  localparam int NUM_KW = 16;

  typedef enum logic [2:0] {
    ST_TOKEN     = 3'd0,
    ST_END       = 3'd1,
    ST_TOO_MANY  = 3'd2,
    ST_TOO_LONG  = 3'd3,
    ST_UNKNOWN   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    KIND_PUNCT     = 3'd0,
    KIND_NUMBER    = 3'd1,
    KIND_IDENT     = 3'd2,
    KIND_AGGREGATE = 3'd3,
    KIND_BASE_TYPE = 3'd4,
    KIND_QUALIFIER = 3'd5,
    KIND_STORAGE   = 3'd6
  } kind_t;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_NUM  = 2'd1,
    MODE_WORD = 2'd2
  } mode_t;

  typedef struct packed {
    status_t                status;
    kind_t                  kind;
    logic [IDX_W-1:0]       token_index;
    logic [LEN_W-1:0]       token_length;
    logic [POS_OUT_W-1:0]   start_position;
    logic [7:0]             punct_char;
    logic                   last;
  } rec_t;

  // keyword text, right-justified: character i sits in byte (len-1-i)
  localparam logic [63:0] KW_WORD [NUM_KW] = '{
    "char", "short", "int", "long", "float", "double", "signed", "unsigned",
    "const", "volatile",
    "enum", "union", "struct",
    "extern", "static", "typedef"
  };
  localparam logic [3:0] KW_LEN [NUM_KW] = '{
    4'd4, 4'd5, 4'd3, 4'd4, 4'd5, 4'd6, 4'd6, 4'd8,
    4'd5, 4'd8,
    4'd4, 4'd5, 4'd6,
    4'd6, 4'd6, 4'd7
  };

  localparam logic [NUM_KW-1:0] ALL_CANDS = '1;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
  endfunction

  function automatic logic is_word_char(logic [7:0] c);
    return is_digit(c) || is_alpha(c) || (c == 8'h5f);
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic is_punct(logic [7:0] c);
    return (c == 8'h28) || (c == 8'h29) || (c == 8'h7b) || (c == 8'h7d) ||
           (c == 8'h5b) || (c == 8'h5d) || (c == 8'h2a) || (c == 8'h2c) ||
           (c == 8'h3b);
  endfunction

  // drop every keyword with no character c at position len
  function automatic logic [NUM_KW-1:0] kw_narrow(logic [NUM_KW-1:0] cand,
                                                  logic [LEN_W-1:0] len,
                                                  logic [7:0] c);
    logic [NUM_KW-1:0] r;
    logic [2:0]        sh;
    r = cand;
    for (int k = 0; k < NUM_KW; k++) begin
      sh = 3'(KW_LEN[k] - 4'd1 - len[3:0]);
      if ((len >= LEN_W'(KW_LEN[k])) || (KW_WORD[k][8*sh +: 8] != c)) begin
        r[k] = 1'b0;
      end
    end
    return r;
  endfunction

  // lowest surviving keyword of exactly this length decides the kind
  function automatic kind_t kw_kind(logic [NUM_KW-1:0] cand, logic [LEN_W-1:0] len);
    kind_t r;
    r = KIND_IDENT;
    for (int k = NUM_KW - 1; k >= 0; k--) begin
      if (cand[k] && (len == LEN_W'(KW_LEN[k]))) begin
        if (k < 8)       r = KIND_BASE_TYPE;
        else if (k < 10) r = KIND_QUALIFIER;
        else if (k < 13) r = KIND_AGGREGATE;
        else             r = KIND_STORAGE;
      end
    end
    return r;
  endfunction

endpackage

/* sv/c_declaration_tokenizer_core.sv */
// c declaration tokenizer: one character in per cycle while ch_stall is low, token records out
// depends on cdt_pkg and cdt_rec_fifo
//
// input channel: ch with ch_valid / ch_stall, one character per request.
// a zero character closes the declaration with an end record carrying the
// token count, or with none after an error. whitespace gives nothing; a
// digit or word run gives one record when the character after it arrives;
// punctuation, errors and the end give a record at once. a character causes
// at most two records (a closed token, then its own); last marks the final one.
// output channel: status, kind, token_index, token_length, start_position,
// punct_char, last with rec_valid / rec_stall.
// each record is registered into the queue and is shown once those ahead leave.
// throughput: one character per cycle while ch_stall is low; the lexer
// state update and the sixteen-way keyword compare are both combinational;
// records leave through a four-entry queue at one per cycle while rec_stall
// is low, and ch_stall rises while it holds more than two, so a stalled
// receiver backs up the input after a few characters and nothing is lost.
// reset clears the lexer state and empties the queue.
module c_declaration_tokenizer_core
  import cdt_pkg::*;
#(
  parameter int MAX_TOKENS    = MAX_TOKENS_DEF,
  parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 ch_valid,
  output logic                 ch_stall,
  input  logic [7:0]           ch,
  output logic                 rec_valid,
  input  logic                 rec_stall,
  output logic [2:0]           status,
  output logic [2:0]           kind,
  output logic [IDX_W-1:0]     token_index,
  output logic [LEN_W-1:0]     token_length,
  output logic [POS_OUT_W-1:0] start_position,
  output logic [7:0]           punct_char,
  output logic                 last
);

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  mode_t                    mode, mode_next;
  logic [LEN_W-1:0]         open_len, open_len_next;
  logic [IDX_W-1:0]         tok_cnt, tok_cnt_next;
  logic [NUM_KW-1:0]        cand, cand_next;
  logic [POSITION_BITS-1:0] char_pos, char_pos_next;
  logic [POSITION_BITS-1:0] open_start, open_start_next;
  logic                     skip, skip_next;

  logic       accept;
  logic       full;
  logic [1:0] push_cnt;
  rec_t       rec_a, rec_b, push0;
  logic       has_a, has_b;
  rec_t       head;

  assign ch_stall = full;
  assign accept   = ch_valid && !full;

  always_comb begin
    logic handled;
    logic cont;
    logic clear;

    mode_next       = mode;
    open_len_next   = open_len;
    tok_cnt_next    = tok_cnt;
    cand_next       = cand;
    char_pos_next   = char_pos;
    open_start_next = open_start;
    skip_next       = skip;
    rec_a   = '0;
    rec_b   = '0;
    has_a   = 1'b0;
    has_b   = 1'b0;
    handled = 1'b0;
    clear   = 1'b0;
    cont    = (mode == MODE_NUM) ? is_digit(ch) : is_word_char(ch);

    if (accept) begin
      if (skip) begin
        clear = (ch == 8'd0);
      end else begin
        if (mode != MODE_NONE) begin
          if (cont) begin
            handled = 1'b1;
            if (open_len >= LEN_W'(MAX_TOKEN_LEN)) begin
              has_a                = 1'b1;
              rec_a.status         = ST_TOO_LONG;
              rec_a.token_index    = IDX_W'(tok_cnt - 1'b1);
              rec_a.start_position = POS_OUT_W'(open_start);
              skip_next            = 1'b1;
              mode_next            = MODE_NONE;
            end else begin
              if (mode == MODE_WORD) begin
                cand_next = kw_narrow(cand, open_len, ch);
              end
              open_len_next = LEN_W'(open_len + 1'b1);
            end
          end else begin
            // token closed by this character, which is handled below
            has_a                = 1'b1;
            rec_a.status         = ST_TOKEN;
            rec_a.kind           = (mode == MODE_NUM) ? KIND_NUMBER : kw_kind(cand, open_len);
            rec_a.token_index    = IDX_W'(tok_cnt - 1'b1);
            rec_a.token_length   = open_len;
            rec_a.start_position = POS_OUT_W'(open_start);
            mode_next            = MODE_NONE;
          end
        end

        if (!handled) begin
          if (ch == 8'd0) begin
            has_b                = 1'b1;
            rec_b.status         = ST_END;
            rec_b.token_index    = tok_cnt;
            rec_b.start_position = POS_OUT_W'(char_pos);
            clear                = 1'b1;
          end else if (!is_space(ch)) begin
            if (tok_cnt >= IDX_W'(MAX_TOKENS)) begin
              has_b                = 1'b1;
              rec_b.status         = ST_TOO_MANY;
              rec_b.token_index    = tok_cnt;
              rec_b.start_position = POS_OUT_W'(char_pos);
              skip_next            = 1'b1;
            end else if (is_word_char(ch)) begin
              mode_next       = is_digit(ch) ? MODE_NUM : MODE_WORD;
              open_len_next   = LEN_W'(1);
              open_start_next = char_pos;
              cand_next       = is_digit(ch) ? ALL_CANDS : kw_narrow(ALL_CANDS, '0, ch);
              tok_cnt_next    = IDX_W'(tok_cnt + 1'b1);
            end else if (is_punct(ch)) begin
              has_b                = 1'b1;
              rec_b.status         = ST_TOKEN;
              rec_b.kind           = KIND_PUNCT;
              rec_b.token_index    = tok_cnt;
              rec_b.token_length   = LEN_W'(1);
              rec_b.start_position = POS_OUT_W'(char_pos);
              rec_b.punct_char     = ch;
              tok_cnt_next         = IDX_W'(tok_cnt + 1'b1);
            end else begin
              has_b                = 1'b1;
              rec_b.status         = ST_UNKNOWN;
              rec_b.token_index    = tok_cnt;
              rec_b.start_position = POS_OUT_W'(char_pos);
              rec_b.punct_char     = ch;
              tok_cnt_next         = IDX_W'(tok_cnt + 1'b1);
              skip_next            = 1'b1;
            end
          end
        end
      end

      if (char_pos < POS_MAX) begin
        char_pos_next = POSITION_BITS'(char_pos + 1'b1);
      end

      if (clear) begin
        mode_next       = MODE_NONE;
        open_len_next   = '0;
        tok_cnt_next    = '0;
        cand_next       = ALL_CANDS;
        char_pos_next   = '0;
        open_start_next = '0;
        skip_next       = 1'b0;
      end
    end

    if (has_b) begin
      rec_b.last = 1'b1;
    end else begin
      rec_a.last = has_a;
    end
  end

  assign push0    = has_a ? rec_a : rec_b;
  assign push_cnt = 2'(has_a) + 2'(has_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_NONE;
      open_len   <= '0;
      tok_cnt    <= '0;
      cand       <= ALL_CANDS;
      char_pos   <= '0;
      open_start <= '0;
      skip       <= 1'b0;
    end else begin
      mode       <= mode_next;
      open_len   <= open_len_next;
      tok_cnt    <= tok_cnt_next;
      cand       <= cand_next;
      char_pos   <= char_pos_next;
      open_start <= open_start_next;
      skip       <= skip_next;
    end
  end

  cdt_rec_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_cnt   (push_cnt),
    .push_rec0  (push0),
    .push_rec1  (rec_b),
    .almost_full(full),
    .head_valid (rec_valid),
    .head_rec   (head),
    .head_stall (rec_stall)
  );

  assign status         = head.status;
  assign kind           = head.kind;
  assign token_index    = head.token_index;
  assign token_length   = head.token_length;
  assign start_position = head.start_position;
  assign punct_char     = head.punct_char;
  assign last           = head.last;

endmodule

/* sv/cdt_rec_fifo.sv */
// small result queue: takes up to two records a cycle, hands out one while head_stall is low
// depends on cdt_pkg for the record type and queue depth
module cdt_rec_fifo
  import cdt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] push_cnt,
  input  rec_t       push_rec0,
  input  rec_t       push_rec1,
  output logic       almost_full,
  output logic       head_valid,
  output rec_t       head_rec,
  input  logic       head_stall
);

  rec_t                 mem [REC_FIFO_DEPTH];
  logic [REC_PTR_W-1:0] wr_ptr;
  logic [REC_PTR_W-1:0] rd_ptr;
  logic [REC_CNT_W-1:0] count;
  logic                 pop;

  assign head_valid  = (count != '0);
  assign head_rec    = mem[rd_ptr];
  assign pop         = head_valid && !head_stall;
  // room for two more records is guaranteed while almost_full is low
  assign almost_full = (count > REC_CNT_W'(REC_FIFO_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wr_ptr] <= push_rec0;
    end
    if (push_cnt == 2'd2) begin
      mem[REC_PTR_W'(wr_ptr + 1'b1)] <= push_rec1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= REC_PTR_W'(wr_ptr + REC_PTR_W'(push_cnt));
      if (pop) begin
        rd_ptr <= REC_PTR_W'(rd_ptr + 1'b1);
      end
      count <= REC_CNT_W'(count + REC_CNT_W'(push_cnt) - REC_CNT_W'(pop));
    end
  end

endmodule

/* sv/cdt_checker.sv */
// port-level checks for the c declaration tokenizer core
// depends on cdt_pkg; bound to c_declaration_tokenizer_core below
module cdt_checker
  import cdt_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 ch_stall,
  input logic                 rec_valid,
  input logic                 rec_stall,
  input logic [2:0]           status,
  input logic [2:0]           kind,
  input logic [IDX_W-1:0]     token_index,
  input logic [LEN_W-1:0]     token_length,
  input logic [POS_OUT_W-1:0] start_position,
  input logic [7:0]           punct_char,
  input logic                 last
);

  // a stalled record holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rec_valid && rec_stall |=> rec_valid && $stable(status) && $stable(kind) &&
      $stable(token_index) && $stable(token_length) && $stable(start_position) &&
      $stable(punct_char) && $stable(last))
    else $error("stalled record changed");

  a_reset_empty: assert property (@(posedge clk) rst |=> !rec_valid)
    else $error("record shown right after reset");

  // input is only held back while records are queued
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !rec_valid |-> !ch_stall)
    else $error("input stalled with nothing queued");

  // end and error records always close the request and have zero length and kind
  a_non_token_last: assert property (@(posedge clk) disable iff (rst)
    rec_valid && (status != ST_TOKEN) |-> last && (token_length == '0) &&
      (kind == KIND_PUNCT))
    else $error("end or error record malformed");

  a_punct_shape: assert property (@(posedge clk) disable iff (rst)
    rec_valid && (status == ST_TOKEN) && (kind == KIND_PUNCT) |->
      (token_length == LEN_W'(1)) && (punct_char != 8'd0))
    else $error("punct record malformed");

endmodule

bind c_declaration_tokenizer_core cdt_checker u_cdt_checker (
  .clk           (clk),
  .rst           (rst),
  .ch_stall      (ch_stall),
  .rec_valid     (rec_valid),
  .rec_stall     (rec_stall),
  .status        (status),
  .kind          (kind),
  .token_index   (token_index),
  .token_length  (token_length),
  .start_position(start_position),
  .punct_char    (punct_char),
  .last          (last)
);
